// ===== rtl/core/hex_color_text_parser_defines.svh =====
// Assertion macros for the hex color text parser RTL.
// Included by every module that asserts; depends on nothing else.
`ifndef HEX_COLOR_TEXT_PARSER_DEFINES_SVH
`define HEX_COLOR_TEXT_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCP_ASSERT(lbl, prop, msg)
`define HCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/hcp_pkg.sv =====
// Shared types, character codes and the hex digit decoder for the hex color parser.
// Used by hcp_core and hex_color_text_parser; depends on nothing.
package hcp_pkg;

  localparam logic       REQ_CHAR   = 1'b0;
  localparam logic       REQ_END    = 1'b1;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] PREFIX_MARK = CH_LOWER_X;
  localparam logic [3:0] CNT_MAX    = 4'd15;
  localparam logic [3:0] DIGITS     = 4'd6;

  typedef enum logic [2:0] {
    PH_LEAD = 3'b001,
    PH_BODY = 3'b010,
    PH_TERM = 3'b100
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

  // {ok, value}: ok is low for any character that is not a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hcp_core.sv =====
// Parser state and its registered update for one character or end beat.
// Depends on hcp_pkg and hex_color_text_parser_defines.svh.
`include "hex_color_text_parser_defines.svh"

module hcp_core
  import hcp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  output res_t  res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  pw_r, pw_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [23:0] dig_r, dig_nxt;
  logic        bad_r, bad_nxt;

  logic [7:0]  c;
  logic [4:0]  hd;
  logic        is_blank;
  logic        is_crlf;
  logic [3:0]  cnt_b;
  logic [7:0]  first_b;
  logic [23:0] dig_b;
  logic        bad_b;
  logic [3:0]  prefix;
  logic        ok;

  assign c        = item.char_code;
  assign hd       = hex_decode(c);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
  assign is_crlf  = (c == CH_CR) || (c == CH_LF);

  // one non-white body character
  always_comb begin
    first_b = first_r;
    dig_b   = dig_r;
    bad_b   = bad_r | (pw_r != 4'd0);
    if (cnt_r == 4'd0) begin
      first_b = c;
      if (c != CH_HASH) begin
        if (!hd[4]) begin
          bad_b = 1'b1;
        end else begin
          dig_b = {20'd0, hd[3:0]};
        end
      end
    end else if (cnt_r == 4'd1 && first_r == CH_ZERO &&
                 (c == CH_LOWER_X || c == CH_UPPER_X)) begin
      first_b = PREFIX_MARK;
      dig_b   = 24'd0;
    end else if (!hd[4]) begin
      bad_b = 1'b1;
    end else begin
      dig_b = {dig_r[19:0], hd[3:0]};
    end
    cnt_b = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 4'd1;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pw_nxt    = pw_r;
    first_nxt = first_r;
    dig_nxt   = dig_r;
    bad_nxt   = bad_r;
    if (item.req_type == REQ_END) begin
      phase_nxt = PH_LEAD;
      cnt_nxt   = 4'd0;
      pw_nxt    = 4'd0;
      first_nxt = 8'd0;
      dig_nxt   = 24'd0;
      bad_nxt   = 1'b0;
    end else if (c == CH_NUL) begin
      if (phase_r != PH_TERM) begin
        phase_nxt = PH_TERM;
      end
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (!is_blank) begin
            phase_nxt = PH_BODY;
            if (is_crlf) begin
              bad_nxt = 1'b1;
              pw_nxt  = 4'd1;
            end else begin
              cnt_nxt   = cnt_b;
              first_nxt = first_b;
              dig_nxt   = dig_b;
              bad_nxt   = bad_b;
            end
          end
        end
        PH_BODY: begin
          if (is_blank || is_crlf) begin
            pw_nxt = (pw_r == CNT_MAX) ? CNT_MAX : pw_r + 4'd1;
          end else begin
            cnt_nxt   = cnt_b;
            first_nxt = first_b;
            dig_nxt   = dig_b;
            bad_nxt   = bad_b;
          end
        end
        PH_TERM: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prefix = 4'd0;
    if (cnt_r != 4'd0) begin
      if (first_r == CH_HASH) begin
        prefix = 4'd1;
      end else if (first_r == PREFIX_MARK) begin
        prefix = 4'd2;
      end
    end
    ok            = !bad_r && (cnt_r == DIGITS + prefix);
    res.valid_res = ok;
    res.red       = ok ? dig_r[23:16] : 8'd0;
    res.green     = ok ? dig_r[15:8]  : 8'd0;
    res.blue      = ok ? dig_r[7:0]   : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      cnt_r   <= 4'd0;
      pw_r    <= 4'd0;
      first_r <= 8'd0;
      dig_r   <= 24'd0;
      bad_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pw_r    <= pw_nxt;
      first_r <= first_nxt;
      dig_r   <= dig_nxt;
      bad_r   <= bad_nxt;
    end
  end

  `HCP_ASSERT(a_end_clears, fire && item.req_type == REQ_END |=> phase_r == PH_LEAD && cnt_r == 4'd0 && !bad_r, "state not cleared after end beat")
  `HCP_ASSERT(a_lead_empty, phase_r == PH_LEAD |-> cnt_r == 4'd0 && pw_r == 4'd0, "body state set before body began")

endmodule

// ===== rtl/core/hex_color_text_parser.sv =====
// Top level of the hex color text parser: input register, parser core, result register.
// Depends on hcp_pkg, hcp_core and hex_color_text_parser_defines.svh.
`include "hex_color_text_parser_defines.svh"

// Takes one character beat per cycle while not stalled and, on an end beat,
// gives one result beat: a valid flag and the red, green and blue bytes of
// an RRGGBB, #RRGGBB or 0xRRGGBB code (zeros when invalid). A beat waits in
// the input register and is folded into the parser state when it leaves; an
// end beat's result is loaded into the output register at that same edge.
// Sustained rate is one beat per cycle; an end beat waits in the input
// register only while a previous result is still held by out_ready low.

module hex_color_text_parser
  import hcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_valid_res,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic  s1_v_r;
  item_t s1_item_r;
  logic  s1_fire;
  logic  out_v_r;
  res_t  out_res_r;
  res_t  core_res;

  assign s1_fire  = s1_v_r && (s1_item_r.req_type == REQ_CHAR || !out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.req_type  <= in_req_type;
      s1_item_r.char_code <= in_char_code;
    end
  end

  hcp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .item  (s1_item_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire && s1_item_r.req_type == REQ_END) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item_r.req_type == REQ_END) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_valid_res = out_res_r.valid_res;
  assign out_red       = out_res_r.red;
  assign out_green     = out_res_r.green;
  assign out_blue      = out_res_r.blue;

  `HCP_ASSERT(a_end_gives_result,
    s1_fire && s1_item_r.req_type == REQ_END |=> out_v_r,
    "end beat produced no result")
  `HCP_ASSERT(a_invalid_zero,
    out_v_r && !out_res_r.valid_res |->
      out_res_r.red == 8'd0 && out_res_r.green == 8'd0 && out_res_r.blue == 8'd0,
    "invalid result with nonzero bytes")
  `HCP_ASSERT(a_stall_held,
    !in_ready |-> s1_v_r && s1_item_r.req_type == REQ_END && out_v_r,
    "input stalled without a blocked end beat")
  `HCP_ASSERT_ALWAYS(a_reset_idle,
    !rst_n |=> !out_v_r && !s1_v_r,
    "pipeline not empty after reset")

endmodule
